### hdl/dom_pkg.sv
// shared types and constants for the delayed output mapper
`default_nettype none

package dom_pkg;

    localparam int MAX_OUTPUTS = 8;
    localparam int WORD_W      = 32;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_SELECT_MAP   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_MASK  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SET_DELAYS   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_DELAYS = 8'd3;

    // source codes in bits 7..5 of a select byte
    localparam logic [2:0] SRC_EXT = 3'd0;
    localparam logic [2:0] SRC_INT = 3'd1;

    typedef struct packed {
        logic [7:0] reset_delay;
        logic [7:0] set_delay;
        logic       invert;
        logic [2:0] src;
        logic [4:0] bit_idx;
    } chan_cfg_t;

endpackage

`default_nettype wire

### hdl/delayed_output_mapper.sv
// top level: input register, run flag, timer bank and result register
// a request is held in the input register, and its result is then written to the result register that drives m_tdata
// throughput: one request per cycle while m_tready is high, set by the single input register and result register
// the result register frees itself in the cycle m_tready is high, so the stream never bubbles
// reset: aresetn low clears the run flag, every delay counter, the output levels and all
// configuration registers; a request held in the input register is dropped at reset
`default_nettype none

module delayed_output_mapper #(
    parameter int NUM_OUTPUTS = 8,
    parameter int DELAY_BITS  = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // [31:0] external_bits, [63:32] internal_bits, [64] start_pulse, [65] stop_pulse
    input  wire logic [dom_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] output_bits, [8] running
    output logic [dom_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dom_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dom_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                                         in_valid_reg;
    logic [dom_pkg::WORD_W-1:0]                   ext_reg;
    logic [dom_pkg::WORD_W-1:0]                   int_reg;
    logic                                         start_reg;
    logic                                         stop_reg;
    logic                                         run_reg;
    logic                                         run_next;
    logic                                         advance;
    logic [dom_pkg::WORD_W-1:0]                   ext_gated;
    logic [dom_pkg::MAX_OUTPUTS-1:0]              levels_next;
    logic                                         out_valid_reg;
    logic [dom_pkg::MAX_OUTPUTS-1:0]              out_bits_reg;
    logic                                         out_run_reg;
    dom_pkg::chan_cfg_t [dom_pkg::MAX_OUTPUTS-1:0] chan_cfg;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // stop is applied after start
    assign run_next  = stop_reg ? 1'b0 : (start_reg ? 1'b1 : run_reg);
    assign ext_gated = run_next ? ext_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ext_reg   <= s_tdata[31:0];
            int_reg   <= s_tdata[63:32];
            start_reg <= s_tdata[64];
            stop_reg  <= s_tdata[65];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                run_reg       <= run_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_bits_reg <= levels_next;
            out_run_reg  <= run_next;
        end
    end

    dom_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chan_cfg  (chan_cfg)
    );

    for (genvar g = 0; g < dom_pkg::MAX_OUTPUTS; g++) begin : gen_chan
        if (g < NUM_OUTPUTS) begin : gen_used
            dom_channel #(
                .DELAY_BITS (DELAY_BITS)
            ) u_channel (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .en         (advance),
                .ext_word   (ext_gated),
                .int_word   (int_reg),
                .cfg        (chan_cfg[g]),
                .level_next (levels_next[g])
            );
        end else begin : gen_unused
            assign levels_next[g] = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_run_reg, out_bits_reg};

endmodule

`default_nettype wire

### hdl/dom_cfg_regs.sv
// configuration registers, split into per-output settings
`default_nettype none

module dom_cfg_regs (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_valid,
    input  wire logic [dom_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [dom_pkg::CFG_DATA_W-1:0]        cfg_data,
    output dom_pkg::chan_cfg_t [dom_pkg::MAX_OUTPUTS-1:0] chan_cfg
);

    logic [63:0] select_map_reg;
    logic [7:0]  invert_mask_reg;
    logic [63:0] set_delays_reg;
    logic [63:0] reset_delays_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_map_reg   <= '0;
            invert_mask_reg  <= '0;
            set_delays_reg   <= '0;
            reset_delays_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dom_pkg::REG_SELECT_MAP:   select_map_reg   <= cfg_data;
                dom_pkg::REG_INVERT_MASK:  invert_mask_reg  <= cfg_data[7:0];
                dom_pkg::REG_SET_DELAYS:   set_delays_reg   <= cfg_data;
                dom_pkg::REG_RESET_DELAYS: reset_delays_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < dom_pkg::MAX_OUTPUTS; i++) begin
            chan_cfg[i].bit_idx     = select_map_reg[8*i +: 5];
            chan_cfg[i].src         = select_map_reg[8*i+5 +: 3];
            chan_cfg[i].invert      = invert_mask_reg[i];
            chan_cfg[i].set_delay   = set_delays_reg[8*i +: 8];
            chan_cfg[i].reset_delay = reset_delays_reg[8*i +: 8];
        end
    end

endmodule

`default_nettype wire

### hdl/dom_channel.sv
// one output: bit pick, set and reset delay counters, driven level
`default_nettype none

module dom_channel #(
    parameter int DELAY_BITS = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic [dom_pkg::WORD_W-1:0] ext_word,
    input  wire logic [dom_pkg::WORD_W-1:0] int_word,
    input  wire dom_pkg::chan_cfg_t         cfg,
    output logic                            level_next
);

    logic [DELAY_BITS-1:0] set_cnt_reg;
    logic [DELAY_BITS-1:0] set_cnt_next;
    logic [DELAY_BITS-1:0] reset_cnt_reg;
    logic [DELAY_BITS-1:0] reset_cnt_next;
    logic                  level_reg;
    logic                  bit_hi;

    always_comb begin
        unique case (cfg.src)
            dom_pkg::SRC_EXT: bit_hi = ext_word[cfg.bit_idx];
            dom_pkg::SRC_INT: bit_hi = int_word[cfg.bit_idx];
            default:          bit_hi = 1'b0;
        endcase
    end

    always_comb begin
        set_cnt_next   = set_cnt_reg;
        reset_cnt_next = reset_cnt_reg;
        level_next     = level_reg;
        if (bit_hi) begin
            reset_cnt_next = cfg.reset_delay[DELAY_BITS-1:0];
            if (set_cnt_reg != '0) begin
                set_cnt_next = set_cnt_reg - DELAY_BITS'(1);
            end else begin
                level_next = !cfg.invert;
            end
        end else begin
            set_cnt_next = cfg.set_delay[DELAY_BITS-1:0];
            if (reset_cnt_reg != '0) begin
                reset_cnt_next = reset_cnt_reg - DELAY_BITS'(1);
            end else begin
                level_next = cfg.invert;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_cnt_reg   <= '0;
            reset_cnt_reg <= '0;
            level_reg     <= 1'b0;
        end else if (en) begin
            set_cnt_reg   <= set_cnt_next;
            reset_cnt_reg <= reset_cnt_next;
            level_reg     <= level_next;
        end
    end

endmodule

`default_nettype wire
